FILE: hw/rtl/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types, cell codes and the 4-to-5 group code table for the encoder.
// ----------------------------------------------------------------------------
package gcr_pkg;

    // a job holds every output byte made by one input item
    localparam int unsigned JOB_BYTES = 4;

    // two-bit cell codes
    localparam logic [1:0] CELL_ONE  = 2'b10;
    localparam logic [1:0] CELL_ZERO = 2'b00;

    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;  // bytes[3] goes out first
        logic [2:0]                count;  // number of valid bytes, 2..4
        logic                      last;   // item closed the stream
    } t_job;

    // fixed 4-to-5 group code
    function automatic logic [4:0] gcr_code(input logic [3:0] nib);
        logic [4:0] code;
        unique case (nib)
            4'h0: code = 5'h0A;
            4'h1: code = 5'h0B;
            4'h2: code = 5'h12;
            4'h3: code = 5'h13;
            4'h4: code = 5'h0E;
            4'h5: code = 5'h0F;
            4'h6: code = 5'h16;
            4'h7: code = 5'h17;
            4'h8: code = 5'h09;
            4'h9: code = 5'h19;
            4'hA: code = 5'h1A;
            4'hB: code = 5'h1B;
            4'hC: code = 5'h0D;
            4'hD: code = 5'h1D;
            4'hE: code = 5'h1E;
            4'hF: code = 5'h15;
        endcase
        return code;
    endfunction

    // every bit becomes one cell, msb cell on top
    function automatic logic [9:0] to_cells(input logic [4:0] bits);
        logic [9:0] cells;
        for (int i = 0; i < 5; i++) begin
            cells[2*i +: 2] = bits[i] ? CELL_ONE : CELL_ZERO;
        end
        return cells;
    endfunction

endpackage

FILE: hw/rtl/gcr_cell_pack.sv
// ----------------------------------------------------------------------------
// gcr_cell_pack
// Codes both nibbles of one byte into cells, joins them to the pending cells
// and cuts the result into a job of packed output bytes. Holds the residue.
// ----------------------------------------------------------------------------
module gcr_cell_pack (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic [7:0]    i_data_byte,
    input  logic [7:0]    i_raw_nibble_mask,
    input  logic          i_last_byte,
    output gcr_pkg::t_job o_job
);
    import gcr_pkg::*;

    logic [5:0]  r_res_cells;
    logic [1:0]  r_res_count;
    logic [5:0]  n_res_cells;
    logic [1:0]  n_res_count;

    logic        hi_raw;
    logic        lo_raw;
    logic [4:0]  hi_bits;
    logic [4:0]  lo_bits;
    logic [9:0]  hi_cells;
    logic [9:0]  lo_cells;
    logic [2:0]  hi_len;
    logic [2:0]  lo_len;
    logic [31:0] acc_hi;
    logic [31:0] acc;
    logic [3:0]  total;
    logic [5:0]  align_sh;
    logic [31:0] word;
    logic [1:0]  rem;

    // nibble coding, raw nibbles are four cells
    always_comb begin
        hi_raw   = (i_raw_nibble_mask[7:4] != 4'd0);
        lo_raw   = (i_raw_nibble_mask[3:0] != 4'd0);
        hi_bits  = hi_raw ? {1'b0, i_data_byte[7:4]} : gcr_code(i_data_byte[7:4]);
        lo_bits  = lo_raw ? {1'b0, i_data_byte[3:0]} : gcr_code(i_data_byte[3:0]);
        hi_cells = to_cells(hi_bits);
        lo_cells = to_cells(lo_bits);
        hi_len   = hi_raw ? 3'd4 : 3'd5;
        lo_len   = lo_raw ? 3'd4 : 3'd5;
    end

    // join residue and new cells, then left align into four bytes
    always_comb begin
        acc_hi   = (32'(r_res_cells) << {hi_len, 1'b0}) | 32'(hi_cells);
        acc      = (acc_hi << {lo_len, 1'b0}) | 32'(lo_cells);
        total    = 4'(r_res_count) + 4'(hi_len) + 4'(lo_len);
        align_sh = 6'd32 - {1'b0, total, 1'b0};
        word     = acc << align_sh;
        rem      = total[1:0];
    end

    // job: whole bytes, plus a zero padded byte on a flush with cells left over
    always_comb begin
        o_job.bytes = word;
        o_job.count = {1'b0, total[3:2]} + 3'((i_last_byte && rem != 2'd0) ? 1 : 0);
        o_job.last  = i_last_byte;
    end

    // leftover cells for the next item
    always_comb begin
        unique case (rem)
            2'd0: n_res_cells = 6'd0;
            2'd1: n_res_cells = {4'd0, acc[1:0]};
            2'd2: n_res_cells = {2'd0, acc[3:0]};
            2'd3: n_res_cells = acc[5:0];
        endcase
        n_res_count = rem;
        if (i_last_byte) begin
            n_res_cells = 6'd0;
            n_res_count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cells <= 6'd0;
            r_res_count <= 2'd0;
        end else if (i_load) begin
            r_res_cells <= n_res_cells;
            r_res_count <= n_res_count;
        end
    end

endmodule

FILE: hw/rtl/gcr_byte_ser.sv
// ----------------------------------------------------------------------------
// gcr_byte_ser
// Holds one job and hands its bytes out one per transfer, first byte first.
// Takes the next job in the cycle its final byte leaves.
// ----------------------------------------------------------------------------
module gcr_byte_ser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  gcr_pkg::t_job i_job,
    output logic          o_ready,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [7:0]    o_cell_byte,
    output logic          o_last_of_run,
    output logic          o_end_of_stream
);
    import gcr_pkg::*;

    logic [JOB_BYTES-1:0][7:0] r_bytes;
    logic [2:0]                r_count;
    logic [1:0]                r_index;
    logic                      r_last;
    logic                      out_xfer;

    assign out_xfer = o_out_valid && !i_out_stall;
    assign o_ready  = (r_count == 3'd0) || (r_count == 3'd1 && !i_out_stall);

    // present the current byte
    assign o_out_valid     = (r_count != 3'd0);
    assign o_cell_byte     = r_bytes[2'd3 - r_index];
    assign o_last_of_run   = (r_count == 3'd1);
    assign o_end_of_stream = (r_count == 3'd1) && r_last;

    // byte counter and index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
            r_index <= 2'd0;
        end else if (i_load) begin
            r_count <= i_job.count;
            r_index <= 2'd0;
        end else if (out_xfer) begin
            r_count <= r_count - 3'd1;
            r_index <= r_index + 2'd1;
        end
    end

    // job payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_job.bytes;
            r_last  <= i_job.last;
        end
    end

endmodule

FILE: hw/rtl/gcr_cell_stream_encoder.sv
// ----------------------------------------------------------------------------
// gcr_cell_stream_encoder
// Codes bytes nibble by nibble into two-bit cells and packs them into bytes.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  input   | in        | i_in_valid / o_in_stall | data_byte, raw_nibble_mask, last_byte
//  output  | out       | o_out_valid / i_out_stall | cell_byte, last_of_run, end_of_stream
//
//  An item is held in the input register, then its 2 to 4 bytes leave one
//  per cycle from the job register while the output is not stalled; the
//  single output byte port sets how fast items can follow.
//  A new item enters while the previous job sends its final byte.
//  Reset is synchronous and active low, and clears the pending cells.
//  A stall on the output holds the current byte and backs up into o_in_stall.
// ----------------------------------------------------------------------------
module gcr_cell_stream_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_raw_nibble_mask,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_cell_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_stream
);
    import gcr_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_data_byte;
    logic [7:0] r_raw_nibble_mask;
    logic       r_last_byte;
    logic       ser_ready;
    logic       job_load;
    logic       in_xfer;
    t_job       job;

    assign job_load   = r_in_valid && ser_ready;
    assign o_in_stall = r_in_valid && !job_load;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_data_byte       <= i_data_byte;
            r_raw_nibble_mask <= i_raw_nibble_mask;
            r_last_byte       <= i_last_byte;
        end
    end

    // coding and packing
    gcr_cell_pack u_pack (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (job_load),
        .i_data_byte       (r_data_byte),
        .i_raw_nibble_mask (r_raw_nibble_mask),
        .i_last_byte       (r_last_byte),
        .o_job             (job)
    );

    // byte output
    gcr_byte_ser u_ser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (job_load),
        .i_job           (job),
        .o_ready         (ser_ready),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cell_byte     (o_cell_byte),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_stream (o_end_of_stream)
    );

endmodule

FILE: hw/rtl/gcr_checker.sv
// ----------------------------------------------------------------------------
// gcr_checker
// Port level checks on the encoder's output channel, bound to the top level.
// ----------------------------------------------------------------------------
module gcr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_cell_byte,
    input logic       o_last_of_run,
    input logic       o_end_of_stream
);

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped under stall");

    // a stalled result keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_cell_byte) && $stable(o_last_of_run)
            && $stable(o_end_of_stream))
        else $error("output payload changed under stall");

    // end of stream only on the final byte of an item
    a_eos_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_stream |-> o_last_of_run)
        else $error("end of stream without last of run");

    // bytes of one item leave without a gap
    a_run_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_run |=> o_out_valid)
        else $error("gap inside the bytes of one item");

endmodule

bind gcr_cell_stream_encoder gcr_checker u_gcr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_cell_byte     (o_cell_byte),
    .o_last_of_run   (o_last_of_run),
    .o_end_of_stream (o_end_of_stream)
);

FILE: tb/tb_gcr_cell_stream_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gcr_cell_stream_encoder
// Drives bytes and nibble masks into the encoder and predicts every packed
// cell byte, with run and stream flags, from an independent model of the
// group code, the cell packing and the pending-cell carry. The input idles
// and the output stalls at random; each output transfer is checked in order.
// ----------------------------------------------------------------------------
module tb_gcr_cell_stream_encoder;

    import gcr_pkg::CELL_ONE;
    import gcr_pkg::CELL_ZERO;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 16;

    // 4-to-5 group code, index is the nibble
    localparam logic [4:0] GROUP_CODE [16] = '{
        5'h0A, 5'h0B, 5'h12, 5'h13, 5'h0E, 5'h0F, 5'h16, 5'h17,
        5'h09, 5'h19, 5'h1A, 5'h1B, 5'h0D, 5'h1D, 5'h1E, 5'h15
    };

    typedef struct packed {
        logic [7:0] cell_byte;
        logic       last_of_run;
        logic       end_of_stream;
    } t_cell_out;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_data_byte;
    logic [7:0] i_raw_nibble_mask;
    logic       i_last_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_cell_byte;
    logic       o_last_of_run;
    logic       o_end_of_stream;

    // predictor state: pending cells, right aligned
    logic [5:0] pend_cells;
    logic [1:0] pend_count;
    t_cell_out  cell_byte_q[$];

    int error_count   = 0;
    int items_sent    = 0;
    int streams_done  = 0;
    int bytes_checked = 0;
    int cycle_count   = 0;
    int in_gap_pct    = 0;
    int out_stall_pct = 0;

    gcr_cell_stream_encoder u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_raw_nibble_mask (i_raw_nibble_mask),
        .i_last_byte       (i_last_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_cell_byte       (o_cell_byte),
        .o_last_of_run     (o_last_of_run),
        .o_end_of_stream   (o_end_of_stream)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("gcr_cell_stream_encoder test failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // idle length: mostly short, now and then long
    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // each nibble either coded (zero) or raw (any nonzero value)
    function automatic logic [7:0] rand_mask();
        logic [3:0] hi;
        logic [3:0] lo;
        hi = $urandom_range(1) ? 4'h0 : 4'($urandom_range(1, 15));
        lo = $urandom_range(1) ? 4'h0 : 4'($urandom_range(1, 15));
        return {hi, lo};
    endfunction

    // expected cell bytes for one accepted byte
    task automatic predict_cell_bytes(input logic [7:0] data, input logic [7:0] mask,
                                      input logic last);
        logic [31:0] acc;
        logic [31:0] tmp;
        logic [4:0]  bits;
        logic [3:0]  nib;
        logic [3:0]  m;
        logic [7:0]  made [4];
        int          width;
        int          nbits;
        int          n;
        t_cell_out   r;
        acc   = 32'(pend_cells);
        nbits = int'(pend_count) * 2;
        n     = 0;
        for (int half = 0; half < 2; half++) begin
            nib = (half == 0) ? data[7:4] : data[3:0];
            m   = (half == 0) ? mask[7:4] : mask[3:0];
            if (m == 4'h0) begin
                bits  = GROUP_CODE[nib];
                width = 5;
            end else begin
                bits  = {1'b0, nib};
                width = 4;
            end
            for (int i = width - 1; i >= 0; i--) begin
                acc   = (acc << 2) | 32'(bits[i] ? CELL_ONE : CELL_ZERO);
                nbits += 2;
            end
        end
        // whole bytes, oldest cells first
        while (nbits >= 8) begin
            tmp     = acc >> (nbits - 8);
            made[n] = tmp[7:0];
            n++;
            nbits -= 8;
        end
        // flush pending cells, zero cells at the bottom
        if (last && nbits > 0) begin
            tmp     = acc << (8 - nbits);
            made[n] = tmp[7:0];
            n++;
            nbits = 0;
        end
        if (last) begin
            pend_cells = 6'd0;
            pend_count = 2'd0;
        end else begin
            tmp        = acc & ((32'd1 << nbits) - 32'd1);
            pend_cells = tmp[5:0];
            pend_count = 2'(nbits / 2);
        end
        for (int k = 0; k < n; k++) begin
            r.cell_byte     = made[k];
            r.last_of_run   = (k == n - 1);
            r.end_of_stream = (k == n - 1) && last;
            cell_byte_q.push_back(r);
        end
    endtask

    // one input transfer; valid stays high when no gap follows
    task automatic send_item(input logic [7:0] data, input logic [7:0] mask,
                             input logic last, input int gap);
        i_in_valid        <= 1'b1;
        i_data_byte       <= data;
        i_raw_nibble_mask <= mask;
        i_last_byte       <= last;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        predict_cell_bytes(data, mask, last);
        items_sent++;
        if (last) streams_done++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every expected byte has come out
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (cell_byte_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_cell_byte();
        t_cell_out want;
        if (cell_byte_q.size() == 0) begin
            report_mismatch($sformatf("unexpected cell byte %02h", o_cell_byte));
        end else begin
            want = cell_byte_q.pop_front();
            if (o_cell_byte !== want.cell_byte)
                report_mismatch($sformatf("cell_byte %02h, want %02h",
                                          o_cell_byte, want.cell_byte));
            if (o_last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run %b, want %b (byte %02h)",
                                          o_last_of_run, want.last_of_run, want.cell_byte));
            if (o_end_of_stream !== want.end_of_stream)
                report_mismatch($sformatf("end_of_stream %b, want %b (byte %02h)",
                                          o_end_of_stream, want.end_of_stream,
                                          want.cell_byte));
        end
        bytes_checked++;
    endtask

    // output side: check each transfer, then pick the next stall
    initial begin
        int hold;
        hold = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) check_cell_byte();
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                hold = pick_gap(out_stall_pct);
                if (hold > 0) begin
                    hold--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // every group code in both nibble positions, closed by a flush
    task automatic test_code_table();
        logic [3:0] nib;
        in_gap_pct    = 30;
        out_stall_pct = 20;
        for (int i = 0; i < 16; i++) begin
            nib = 4'(i);
            send_item({nib, ~nib}, 8'h00, (i == 15), pick_gap(in_gap_pct));
        end
        wait_for_drain();
    endtask

    // raw nibbles, field extremes and flushes that leave 0 to 2 cells to pad
    task automatic test_raw_and_flush();
        in_gap_pct    = 30;
        out_stall_pct = 20;
        send_item(8'hFF, 8'hFF, 1'b1, pick_gap(in_gap_pct));  // exact fit, no flush byte
        send_item(8'h00, 8'h00, 1'b0, pick_gap(in_gap_pct));  // two cells left over
        send_item(8'h00, 8'hFF, 1'b1, pick_gap(in_gap_pct));  // flush two cells
        send_item(8'hA5, 8'hF0, 1'b0, pick_gap(in_gap_pct));
        send_item(8'h5A, 8'h0F, 1'b0, pick_gap(in_gap_pct));
        send_item(8'h3C, 8'h01, 1'b0, pick_gap(in_gap_pct));  // three cells pending
        send_item(8'hFF, 8'h00, 1'b1, pick_gap(in_gap_pct));  // four bytes out
        send_item(8'h12, 8'h10, 1'b1, pick_gap(in_gap_pct));  // flush one cell
        wait_for_drain();
    endtask

    // streams of random length and content, sender paused now and then
    task automatic test_random_streams(input int count);
        int sent;
        int len;
        sent          = 0;
        in_gap_pct    = 30;
        out_stall_pct = 25;
        while (sent < count) begin
            // mostly proper streams, some single bytes as noise
            len = ($urandom_range(9) < 8) ? $urandom_range(2, 8) : 1;
            for (int k = 0; k < len && sent < count; k++) begin
                send_item(8'($urandom), rand_mask(),
                          (len == 1) ? 1'($urandom_range(1)) : (k == len - 1 || sent == count - 1),
                          pick_gap(in_gap_pct));
                sent++;
            end
            if ($urandom_range(5) == 0) wait_for_drain();
        end
        wait_for_drain();
    endtask

    // back to back input under given output pressure
    task automatic test_streaming(input int count, input int stall_pct);
        in_gap_pct    = 0;
        out_stall_pct = stall_pct;
        for (int k = 0; k < count; k++) begin
            send_item(8'($urandom), rand_mask(),
                      ($urandom_range(4) == 0) || (k == count - 1), 0);
        end
        wait_for_drain();
    endtask

    initial begin
        pend_cells = 6'd0;
        pend_count = 2'd0;
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_data_byte       <= 8'h00;
        i_raw_nibble_mask <= 8'h00;
        i_last_byte       <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_code_table();
        test_raw_and_flush();
        test_random_streams(51);
        test_streaming(25, 0);
        test_streaming(30, 60);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (cell_byte_q.size() != 0)
            report_mismatch($sformatf("%0d cell bytes never came out", cell_byte_q.size()));

        $display("covered %0d input bytes in %0d streams, %0d cell bytes checked",
                 items_sent, streams_done, bytes_checked);
        $display("all group codes, raw nibbles, flushes of 0..3 cells, random idle and stall");
        if (error_count == 0) begin
            $display("gcr_cell_stream_encoder test passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("gcr_cell_stream_encoder test failed");
        end
        $finish;
    end

endmodule
